### src/msq_pkg.sv
// Shared constants for the Markov step sequencer.
`timescale 1ns / 1ps

package msq_pkg;

    // Fixed field widths of the item payloads.
    localparam int STEP_W    = 3;
    localparam int JUMP_W    = 8;
    localparam int GATE_W    = 8;
    localparam int BYTE_W    = 8;

    // Configuration register file: eight rows of eight weight bytes.
    localparam int ROW_COUNT = 8;
    localparam int ROW_W     = ROW_COUNT * BYTE_W;
    localparam int CFG_IDX_W = 3;

    // Bit positions of the input fields inside tdata.
    localparam int CLK_POS   = 0;
    localparam int JUMP_POS  = 1;
    localparam int DRAW_POS  = JUMP_POS + JUMP_W;

    // Result payload width, padded to whole bytes.
    localparam int OUT_W     = ((STEP_W + GATE_W + 7) / 8) * 8;

endpackage

### src/msq_regs.sv
// Transition weight register file with one row read port.
`timescale 1ns / 1ps

module msq_regs
    import msq_pkg::*;
#(
    parameter int NUM_STEPS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ROW_W-1:0]     i_cfg_data,
    input  logic [STEP_W-1:0]    i_sel,
    output logic [ROW_W-1:0]     o_row
);

    localparam int SEL_W = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;

    logic [ROW_W-1:0] r_rows [NUM_STEPS];

    // Rows reset to the identity: each step stays where it is.
    // Writes to rows that the step range never reaches are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_STEPS; r++) begin
                r_rows[r] <= ROW_W'({BYTE_W{1'b1}}) << (BYTE_W * r);
            end
        end else if (i_cfg_we && (int'(i_cfg_idx) < NUM_STEPS)) begin
            r_rows[i_cfg_idx[SEL_W-1:0]] <= i_cfg_data;
        end
    end

    // The current step always stays below the step count.
    assign o_row = r_rows[i_sel[SEL_W-1:0]];

endmodule

### src/msq_pick.sv
// Weighted next-step selection for one row of transition weights.
`timescale 1ns / 1ps

module msq_pick
    import msq_pkg::*;
#(
    parameter int NUM_STEPS   = 8,
    parameter int WEIGHT_BITS = 8,
    parameter int RAND_BITS   = 16
) (
    input  logic [ROW_W-1:0]     i_row,
    input  logic [RAND_BITS-1:0] i_draw,
    input  logic [STEP_W-1:0]    i_cur,
    output logic [STEP_W-1:0]    o_next
);

    localparam int SUM_W = WEIGHT_BITS + 3;
    localparam int CMP_W = SUM_W + RAND_BITS;
    localparam logic [SUM_W-1:0] FullScale = SUM_W'((1 << WEIGHT_BITS) - 1);

    logic [SUM_W-1:0] cum [NUM_STEPS];
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] total;
    logic [CMP_W-1:0] target;

    // Running sums of the weights, using the low bits of each byte.
    always_comb begin
        sum = '0;
        for (int k = 0; k < NUM_STEPS; k++) begin
            sum    = sum + SUM_W'(i_row[BYTE_W * k +: WEIGHT_BITS]);
            cum[k] = sum;
        end
    end

    // The stop bucket lifts the total to full scale when the row is short.
    assign total  = (sum < FullScale) ? FullScale : sum;
    assign target = CMP_W'(i_draw) * CMP_W'(total);

    // First bucket whose scaled running sum passes the target; the stop
    // bucket keeps the current step.
    always_comb begin
        o_next = i_cur;
        for (int k = NUM_STEPS - 1; k >= 0; k--) begin
            if ((CMP_W'(cum[k]) << RAND_BITS) > target) begin
                o_next = STEP_W'(k);
            end
        end
    end

endmodule

### src/markov_step_sequencer.sv
// Top level of the Markov step sequencer with stream channels.
//
// One input item is one sample tick: tdata carries clock_level in bit 0,
// jump_levels in bits 8:1 and random_draw from bit 9 up. On a rising edge
// of clock_level the step moves to a successor drawn from the current
// step's row of transition weights; a rising edge on a jump line then
// forces that step, the highest-numbered line winning. Every input item
// yields exactly one result item with the step and its gate.
// Weight rows are written through i_cfg_we / i_cfg_idx / i_cfg_data,
// one 64-bit row per index; the user must write them only while no
// item is in flight, as the block itself does not enforce it. An input
// item is taken by the input register; the row sum, one multiply and
// the compares sit in front of the result register, which also updates
// the step state. Throughput is one item per clock while results flow.
// Reset (synchronous, active low) empties both registers, returns the
// step to zero, clears the edge detectors and loads the identity rows.
// When the receiver stalls, the result holds and the input register
// still takes one more item; after that o_s_axis_tready drops until the
// result is taken.
`timescale 1ns / 1ps

module markov_step_sequencer
    import msq_pkg::*;
#(
    parameter int NUM_STEPS   = 8,
    parameter int WEIGHT_BITS = 8,
    parameter int RAND_BITS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input item: clock_level, jump_levels, random_draw, zero padding.
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [((DRAW_POS + RAND_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // Result item: current_step, gate_onehot, zero padding.
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [OUT_W-1:0]     o_m_axis_tdata,
    // Weight row writes.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ROW_W-1:0]     i_cfg_data
);

    // Input register.
    logic                 r_in_valid;
    logic                 r_in_clk;
    logic [JUMP_W-1:0]    r_in_jump;
    logic [RAND_BITS-1:0] r_in_draw;

    // Result register.
    logic                 r_out_valid;
    logic [STEP_W-1:0]    r_out_step;
    logic [GATE_W-1:0]    r_out_gate;

    // Sequencer state.
    logic [STEP_W-1:0]    r_step;
    logic                 r_clk_prev;
    logic [JUMP_W-1:0]    r_jump_prev;

    logic                 in_accept;
    logic                 advance;
    logic [ROW_W-1:0]     row;
    logic [STEP_W-1:0]    pick_step;
    logic [JUMP_W-1:0]    jump_rise;
    logic [STEP_W-1:0]    n_step;
    logic [GATE_W-1:0]    n_gate;

    // Handshake: the item moves on when the result register is free.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    msq_regs #(
        .NUM_STEPS (NUM_STEPS)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sel      (r_step),
        .o_row      (row)
    );

    msq_pick #(
        .NUM_STEPS   (NUM_STEPS),
        .WEIGHT_BITS (WEIGHT_BITS),
        .RAND_BITS   (RAND_BITS)
    ) u_pick (
        .i_row  (row),
        .i_draw (r_in_draw),
        .i_cur  (r_step),
        .o_next (pick_step)
    );

    // Next step: clock edge draws a successor, then jump edges override.
    assign jump_rise = r_in_jump & ~r_jump_prev;

    always_comb begin
        n_step = r_step;
        if (r_in_clk && !r_clk_prev) begin
            n_step = pick_step;
        end
        for (int k = 0; k < NUM_STEPS; k++) begin
            if (jump_rise[k]) begin
                n_step = STEP_W'(k);
            end
        end
    end

    assign n_gate = r_in_clk ? (GATE_W'(1) << n_step) : '0;

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_clk  <= i_s_axis_tdata[CLK_POS];
            r_in_jump <= i_s_axis_tdata[JUMP_POS +: JUMP_W];
            r_in_draw <= i_s_axis_tdata[DRAW_POS +: RAND_BITS];
        end
    end

    // Sequencer state and result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_clk_prev  <= 1'b0;
            r_jump_prev <= '0;
        end else begin
            r_out_valid <= advance || (r_out_valid && !i_m_axis_tready);
            if (advance) begin
                r_step      <= n_step;
                r_clk_prev  <= r_in_clk;
                r_jump_prev <= r_in_jump;
            end
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_step <= n_step;
            r_out_gate <= n_gate;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_W - STEP_W - GATE_W){1'b0}}, r_out_gate, r_out_step};

endmodule

### src/msq_checker.sv
// Port-level checks for the Markov step sequencer, bound to the top level.
`timescale 1ns / 1ps

module msq_checker
    import msq_pkg::*;
#(
    parameter int NUM_STEPS = 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata
);

    logic [STEP_W-1:0] step;
    logic [GATE_W-1:0] gate;

    assign step = o_m_axis_tdata[STEP_W-1:0];
    assign gate = o_m_axis_tdata[STEP_W +: GATE_W];

    // The step never leaves the configured range.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (int'(step) < NUM_STEPS))
        else $error("step index out of range");

    // The gate is either off or exactly the bit of the reported step.
    a_gate_matches_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((gate == '0) || (gate == (GATE_W'(1) << step))))
        else $error("gate does not match step");

    // No result appears in the cycle right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds its value.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind markov_step_sequencer msq_checker #(
    .NUM_STEPS (NUM_STEPS)
) u_msq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
